/* rtl/iwd_pkg.sv */
// ----------------------------------------------------------------------------
// iwd_pkg: shared types and constants of the instruction word decoder
// Operation codes, field widths and program address constants.
// ----------------------------------------------------------------------------
`default_nettype none

package iwd_pkg;

  localparam int unsigned WordW = 16;
  localparam int unsigned AddrW = 12;
  localparam int unsigned RegW  = 4;
  localparam int unsigned ByteW = 8;
  localparam int unsigned OpW   = 6;

  // First word after reset sits at StartAddr; the counter holds the address
  // of the last word taken, so it starts one step below.
  localparam logic [AddrW-1:0] StartAddr = 12'h200;
  localparam logic [AddrW-1:0] AddrStep  = 12'h002;
  localparam logic [AddrW-1:0] AddrReset = StartAddr - AddrStep;

  typedef enum logic [OpW-1:0] {
    OP_NONE     = 6'd0,
    OP_JUMP     = 6'd1,
    OP_CALL     = 6'd2,
    OP_SET_IDX  = 6'd3,
    OP_JUMP_OFS = 6'd4,
    OP_CLS      = 6'd5,
    OP_RET      = 6'd6,
    OP_SKEQ_K   = 6'd7,
    OP_SKNE_K   = 6'd8,
    OP_SET_K    = 6'd9,
    OP_ADD_K    = 6'd10,
    OP_RAND     = 6'd11,
    OP_SKEQ_R   = 6'd12,
    OP_SKNE_R   = 6'd13,
    OP_MOV      = 6'd14,
    OP_OR       = 6'd15,
    OP_AND      = 6'd16,
    OP_XOR      = 6'd17,
    OP_ADD      = 6'd18,
    OP_SUB      = 6'd19,
    OP_SUBN     = 6'd20,
    OP_SHR      = 6'd21,
    OP_SHL      = 6'd22,
    OP_SKP_KEY  = 6'd23,
    OP_SKNP_KEY = 6'd24,
    OP_WAIT_KEY = 6'd25,
    OP_GET_DT   = 6'd26,
    OP_SET_DT   = 6'd27,
    OP_SET_ST   = 6'd28,
    OP_ADD_IDX  = 6'd29,
    OP_FONT     = 6'd30,
    OP_BCD      = 6'd31,
    OP_STORE    = 6'd32,
    OP_LOAD     = 6'd33,
    OP_DRAW     = 6'd34
  } op_kind_e;

  // Top nibble of the word
  localparam logic [3:0] TopSys    = 4'h0;
  localparam logic [3:0] TopJump   = 4'h1;
  localparam logic [3:0] TopCall   = 4'h2;
  localparam logic [3:0] TopSkEqK  = 4'h3;
  localparam logic [3:0] TopSkNeK  = 4'h4;
  localparam logic [3:0] TopSkEqR  = 4'h5;
  localparam logic [3:0] TopSetK   = 4'h6;
  localparam logic [3:0] TopAddK   = 4'h7;
  localparam logic [3:0] TopAlu    = 4'h8;
  localparam logic [3:0] TopSkNeR  = 4'h9;
  localparam logic [3:0] TopSetIdx = 4'hA;
  localparam logic [3:0] TopJmpOfs = 4'hB;
  localparam logic [3:0] TopRand   = 4'hC;
  localparam logic [3:0] TopDraw   = 4'hD;
  localparam logic [3:0] TopKey    = 4'hE;
  localparam logic [3:0] TopMisc   = 4'hF;

  // Full words of the 0NNN group
  localparam logic [WordW-1:0] WordCls = 16'h00E0;
  localparam logic [WordW-1:0] WordRet = 16'h00EE;

  // Low nibble of the 8XYn group
  localparam logic [3:0] AluMov  = 4'h0;
  localparam logic [3:0] AluOr   = 4'h1;
  localparam logic [3:0] AluAnd  = 4'h2;
  localparam logic [3:0] AluXor  = 4'h3;
  localparam logic [3:0] AluAdd  = 4'h4;
  localparam logic [3:0] AluSub  = 4'h5;
  localparam logic [3:0] AluShr  = 4'h6;
  localparam logic [3:0] AluSubn = 4'h7;
  localparam logic [3:0] AluShl  = 4'hE;

  // Low byte of the EX and FX groups
  localparam logic [ByteW-1:0] KeySkp   = 8'h9E;
  localparam logic [ByteW-1:0] KeySknp  = 8'hA1;
  localparam logic [ByteW-1:0] MiscGetDt = 8'h07;
  localparam logic [ByteW-1:0] MiscWaitK = 8'h0A;
  localparam logic [ByteW-1:0] MiscSetDt = 8'h15;
  localparam logic [ByteW-1:0] MiscSetSt = 8'h18;
  localparam logic [ByteW-1:0] MiscAddI  = 8'h1E;
  localparam logic [ByteW-1:0] MiscFont  = 8'h29;
  localparam logic [ByteW-1:0] MiscBcd   = 8'h33;
  localparam logic [ByteW-1:0] MiscStore = 8'h55;
  localparam logic [ByteW-1:0] MiscLoad  = 8'h65;

endpackage

`default_nettype wire

/* rtl/iwd_if.sv */
// ----------------------------------------------------------------------------
// iwd_if: request and result channels of the instruction word decoder
// Valid/ready channels; a request or result moves when both are high.
// ----------------------------------------------------------------------------
`default_nettype none

interface iwd_req_if;
  import iwd_pkg::*;

  logic             valid;
  logic             ready;
  logic [WordW-1:0] instr_word;

  modport source (output valid, output instr_word, input ready);
  modport sink   (input valid, input instr_word, output ready);
endinterface

interface iwd_rsp_if;
  import iwd_pkg::*;

  logic             valid;
  logic             ready;
  logic [OpW-1:0]   op_kind;
  logic [RegW-1:0]  reg_x;
  logic [RegW-1:0]  reg_y;
  logic [ByteW-1:0] imm_byte;
  logic [AddrW-1:0] imm_addr;
  logic [RegW-1:0]  nibble;
  logic [AddrW-1:0] instr_addr;

  modport source (
    output valid, output op_kind, output reg_x, output reg_y, output imm_byte,
    output imm_addr, output nibble, output instr_addr, input ready
  );
  modport sink (
    input valid, input op_kind, input reg_x, input reg_y, input imm_byte,
    input imm_addr, input nibble, input instr_addr, output ready
  );
endinterface

`default_nettype wire

/* rtl/instruction_word_decoder.sv */
// ----------------------------------------------------------------------------
// instruction_word_decoder: CHIP-8 instruction word decoder
// Tags each word with its program address and decodes its operation.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one 16-bit instruction word per request, in program order.
//   rsp_o carries one result per request: the dense operation code (0 for an
//   unrecognized word), the raw operand slices X, Y, NN, NNN, N and the
//   program address of the word.
//   A request passes through the input register, the classifier, then the
//   result register. Throughput is one word per cycle while rsp_o.ready is high;
//   the two register stages each take a new entry whenever they are empty or
//   are being emptied in the same cycle, so a stalled result does not stop
//   a request from entering while the input stage is free.
//   The address counter advances by 2 on every accepted request and wraps at
//   4096. Reset empties both stages and sets the counter so that the first
//   word after reset is tagged 0x200.
//   When the receiver holds ready low, the result register holds its item,
//   the input stage fills and then holds, and req_i.ready drops; nothing is
//   lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module instruction_word_decoder (
  input  logic      clk_i,
  input  logic      rst_ni,
  iwd_req_if.sink   req_i,
  iwd_rsp_if.source rsp_o
);
  import iwd_pkg::*;

  // Address of the last accepted word
  logic [AddrW-1:0] pc_q, pc_d;

  // Input stage
  logic             s1_valid_q;
  logic [WordW-1:0] s1_word_q;
  logic [AddrW-1:0] s1_addr_q;
  logic             s1_ready;
  logic             req_fire;

  // Result stage
  logic             s2_valid_q;
  logic             s2_ready;
  logic             s1_fire;
  op_kind_e         s1_kind;
  op_kind_e         s2_kind_q;
  logic [WordW-1:0] s2_word_q;
  logic [AddrW-1:0] s2_addr_q;

  // Advance a stage when it is empty or its item leaves this cycle
  assign s2_ready    = !s2_valid_q || rsp_o.ready;
  assign s1_ready    = !s1_valid_q || s2_ready;
  assign req_i.ready = s1_ready;
  assign req_fire    = req_i.valid && s1_ready;
  assign s1_fire     = s1_valid_q && s2_ready;

  assign pc_d = req_fire ? pc_q + AddrStep : pc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q       <= AddrReset;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      pc_q <= pc_d;
      if (s1_ready) s1_valid_q <= req_i.valid;
      if (s2_ready) s2_valid_q <= s1_valid_q;
    end
  end

  // Capture the word together with its program address
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      s1_word_q <= req_i.instr_word;
      s1_addr_q <= pc_d;
    end
  end

  iwd_decode u_decode (
    .word_i    (s1_word_q),
    .op_kind_o (s1_kind)
  );

  // Register the decoded result; hold it while the receiver stalls
  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      s2_kind_q <= s1_kind;
      s2_word_q <= s1_word_q;
      s2_addr_q <= s1_addr_q;
    end
  end

  assign rsp_o.valid      = s2_valid_q;
  assign rsp_o.op_kind    = s2_kind_q;
  assign rsp_o.reg_x      = s2_word_q[11:8];
  assign rsp_o.reg_y      = s2_word_q[7:4];
  assign rsp_o.imm_byte   = s2_word_q[7:0];
  assign rsp_o.imm_addr   = s2_word_q[11:0];
  assign rsp_o.nibble     = s2_word_q[3:0];
  assign rsp_o.instr_addr = s2_addr_q;

  // The counter moves exactly by one step per accepted request
  a_pc_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> (pc_q == $past(pc_q) + AddrStep) && (s1_addr_q == pc_q))
    else $error("address counter did not step with the accepted request");

  a_pc_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_fire |=> $stable(pc_q))
    else $error("address counter moved without a request");

  // A blocked input stage keeps its word and address
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s2_ready) |=> s1_valid_q && $stable(s1_word_q)
      && $stable(s1_addr_q))
    else $error("input stage lost its item while blocked");

  // Operand slices overlap in the word and must agree
  a_slices: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (rsp_o.imm_addr[7:0] == rsp_o.imm_byte)
      && (rsp_o.imm_addr[11:8] == rsp_o.reg_x)
      && (rsp_o.imm_byte[3:0] == rsp_o.nibble)
      && (rsp_o.imm_byte[7:4] == rsp_o.reg_y))
    else $error("operand fields disagree");

endmodule

`default_nettype wire

/* rtl/iwd_decode.sv */
// ----------------------------------------------------------------------------
// iwd_decode: opcode classifier
// Maps one 16-bit word to its dense operation code, 0 when not recognized.
// ----------------------------------------------------------------------------
`default_nettype none

module iwd_decode (
  input  logic [iwd_pkg::WordW-1:0] word_i,
  output iwd_pkg::op_kind_e         op_kind_o
);
  import iwd_pkg::*;

  logic [3:0]       top;
  logic [3:0]       lo4;
  logic [ByteW-1:0] lo8;

  assign top = word_i[15:12];
  assign lo4 = word_i[3:0];
  assign lo8 = word_i[7:0];

  always_comb begin
    op_kind_o = OP_NONE;
    case (top)
      TopJump:   op_kind_o = OP_JUMP;
      TopCall:   op_kind_o = OP_CALL;
      TopSetIdx: op_kind_o = OP_SET_IDX;
      TopJmpOfs: op_kind_o = OP_JUMP_OFS;
      TopSys: begin
        if (word_i == WordCls) op_kind_o = OP_CLS;
        else if (word_i == WordRet) op_kind_o = OP_RET;
      end
      TopSkEqK:  op_kind_o = OP_SKEQ_K;
      TopSkNeK:  op_kind_o = OP_SKNE_K;
      TopSetK:   op_kind_o = OP_SET_K;
      TopAddK:   op_kind_o = OP_ADD_K;
      TopRand:   op_kind_o = OP_RAND;
      TopSkEqR:  if (lo4 == 4'h0) op_kind_o = OP_SKEQ_R;
      TopSkNeR:  if (lo4 == 4'h0) op_kind_o = OP_SKNE_R;
      TopAlu: begin
        case (lo4)
          AluMov:  op_kind_o = OP_MOV;
          AluOr:   op_kind_o = OP_OR;
          AluAnd:  op_kind_o = OP_AND;
          AluXor:  op_kind_o = OP_XOR;
          AluAdd:  op_kind_o = OP_ADD;
          AluSub:  op_kind_o = OP_SUB;
          AluSubn: op_kind_o = OP_SUBN;
          AluShr:  op_kind_o = OP_SHR;
          AluShl:  op_kind_o = OP_SHL;
          default: op_kind_o = OP_NONE;
        endcase
      end
      TopKey: begin
        if (lo8 == KeySkp) op_kind_o = OP_SKP_KEY;
        else if (lo8 == KeySknp) op_kind_o = OP_SKNP_KEY;
      end
      TopMisc: begin
        case (lo8)
          MiscWaitK: op_kind_o = OP_WAIT_KEY;
          MiscGetDt: op_kind_o = OP_GET_DT;
          MiscSetDt: op_kind_o = OP_SET_DT;
          MiscSetSt: op_kind_o = OP_SET_ST;
          MiscAddI:  op_kind_o = OP_ADD_IDX;
          MiscFont:  op_kind_o = OP_FONT;
          MiscBcd:   op_kind_o = OP_BCD;
          MiscStore: op_kind_o = OP_STORE;
          MiscLoad:  op_kind_o = OP_LOAD;
          default:   op_kind_o = OP_NONE;
        endcase
      end
      TopDraw:   op_kind_o = OP_DRAW;
      default:   op_kind_o = OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

/* tb/iwd_decode_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iwd_decode_checker: result checker of the instruction word decoder
// Watches both channels, tags each request with its program address, decodes
// it on the side and compares every result field with the oldest prediction.
// ----------------------------------------------------------------------------

module iwd_decode_checker (
  input  logic clk_i,
  input  logic rst_ni,
  iwd_req_if   req_i,
  iwd_rsp_if   rsp_i,
  output int   fail_count_o,
  output int   pending_o,
  output int   result_count_o,
  output int   ops_seen_o
);
  import iwd_pkg::*;

  localparam int unsigned ReportLimit = 10;
  localparam int unsigned NumOps      = 35;

  typedef struct packed {
    logic [OpW-1:0]   op;
    logic [RegW-1:0]  x;
    logic [RegW-1:0]  y;
    logic [ByteW-1:0] nn;
    logic [AddrW-1:0] nnn;
    logic [RegW-1:0]  n;
    logic [AddrW-1:0] addr;
  } decoded_t;

  decoded_t          decoded_q[$];
  logic [AddrW-1:0]  prog_addr = AddrReset;
  logic [NumOps-1:0] ops_hit;

  function automatic op_kind_e classify_word(input logic [WordW-1:0] w);
    op_kind_e op;
    op = OP_NONE;
    case (w[15:12])
      TopJump:   op = OP_JUMP;
      TopCall:   op = OP_CALL;
      TopSetIdx: op = OP_SET_IDX;
      TopJmpOfs: op = OP_JUMP_OFS;
      TopSkEqK:  op = OP_SKEQ_K;
      TopSkNeK:  op = OP_SKNE_K;
      TopSetK:   op = OP_SET_K;
      TopAddK:   op = OP_ADD_K;
      TopRand:   op = OP_RAND;
      TopDraw:   op = OP_DRAW;
      TopSys: begin
        if (w == WordCls) op = OP_CLS;
        else if (w == WordRet) op = OP_RET;
      end
      TopSkEqR: begin
        if (w[3:0] == '0) op = OP_SKEQ_R;
      end
      TopSkNeR: begin
        if (w[3:0] == '0) op = OP_SKNE_R;
      end
      TopAlu: begin
        // shifts match on the low nibble only, Y is a don't-care
        case (w[3:0])
          AluMov:  op = OP_MOV;
          AluOr:   op = OP_OR;
          AluAnd:  op = OP_AND;
          AluXor:  op = OP_XOR;
          AluAdd:  op = OP_ADD;
          AluSub:  op = OP_SUB;
          AluSubn: op = OP_SUBN;
          AluShr:  op = OP_SHR;
          AluShl:  op = OP_SHL;
          default: op = OP_NONE;
        endcase
      end
      TopKey: begin
        if (w[7:0] == KeySkp) op = OP_SKP_KEY;
        else if (w[7:0] == KeySknp) op = OP_SKNP_KEY;
      end
      TopMisc: begin
        case (w[7:0])
          MiscWaitK: op = OP_WAIT_KEY;
          MiscGetDt: op = OP_GET_DT;
          MiscSetDt: op = OP_SET_DT;
          MiscSetSt: op = OP_SET_ST;
          MiscAddI:  op = OP_ADD_IDX;
          MiscFont:  op = OP_FONT;
          MiscBcd:   op = OP_BCD;
          MiscStore: op = OP_STORE;
          MiscLoad:  op = OP_LOAD;
          default:   op = OP_NONE;
        endcase
      end
      default: op = OP_NONE;
    endcase
    return op;
  endfunction

  function automatic decoded_t decode_word(input logic [WordW-1:0] w,
                                           input logic [AddrW-1:0] addr);
    decoded_t d;
    d.op   = classify_word(w);
    d.x    = w[11:8];
    d.y    = w[7:4];
    d.nn   = w[7:0];
    d.nnn  = w[11:0];
    d.n    = w[3:0];
    d.addr = addr;
    return d;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    decoded_t got;
    decoded_t want;
    logic     bad;
    if (!rst_ni) begin
      decoded_q.delete();
      prog_addr      = AddrReset;
      ops_hit        = '0;
      fail_count_o   = 0;
      pending_o      = 0;
      result_count_o = 0;
      ops_seen_o     = 0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        got = '{rsp_i.op_kind, rsp_i.reg_x, rsp_i.reg_y, rsp_i.imm_byte,
                rsp_i.imm_addr, rsp_i.nibble, rsp_i.instr_addr};
        result_count_o++;
        if (decoded_q.size() == 0) begin
          if (fail_count_o < ReportLimit)
            $display("%0t: result op %0d addr %h with no request outstanding",
                     $time, got.op, got.addr);
          fail_count_o++;
        end else begin
          want = decoded_q.pop_front();
          bad  = (got.op !== want.op) || (got.x !== want.x) || (got.y !== want.y) ||
                 (got.nn !== want.nn) || (got.nnn !== want.nnn) ||
                 (got.n !== want.n) || (got.addr !== want.addr);
          if (bad) begin
            if (fail_count_o < ReportLimit) begin
              $display("%0t: expected op %0d x %h y %h nn %h nnn %h n %h addr %h", $time,
                       want.op, want.x, want.y, want.nn, want.nnn, want.n, want.addr);
              $display("%0t:   actual op %0d x %h y %h nn %h nnn %h n %h addr %h", $time,
                       got.op, got.x, got.y, got.nn, got.nnn, got.n, got.addr);
            end
            fail_count_o++;
          end else if (got.op < NumOps) begin
            ops_hit[got.op] = 1'b1;
          end
        end
      end
      // advance the address before tagging, first request lands on StartAddr
      if (req_i.valid && req_i.ready) begin
        prog_addr = prog_addr + AddrStep;
        decoded_q.push_back(decode_word(req_i.instr_word, prog_addr));
      end
      pending_o  = decoded_q.size();
      ops_seen_o = $countones(ops_hit);
    end
  end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: regression of the instruction word decoder
// Feeds directed words for every operation and the unmatched forms, then
// random mostly well-formed words over three pacing phases; a side checker
// predicts and compares.
// ----------------------------------------------------------------------------

module testbench;
  import iwd_pkg::*;

  localparam int unsigned CycleLimit   = 100000;
  localparam int unsigned PhaseItems   = 400;
  // requests over the whole run, directed part included
  localparam int unsigned TotalItems   = 1200;
  localparam int unsigned SettleCycles = 10;

  logic        clk_i;
  logic        rst_ni;
  int          send_idle_pct;
  int          recv_idle_pct;
  int unsigned cycle_count = 0;
  int unsigned words_sent;
  int          fail_count;
  int          pending;
  int          result_count;
  int          ops_seen;

  iwd_req_if req_if ();
  iwd_rsp_if rsp_if ();

  instruction_word_decoder uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  iwd_decode_checker u_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_i          (req_if),
    .rsp_i          (rsp_if),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .result_count_o (result_count),
    .ops_seen_o     (ops_seen)
  );

  // 10 ns clock, low for the first half period
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Result side: hold ready low in reset, then drop it at random per the
  // current phase, and hold it high when the phase calls for no stalls.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: end the run once the cycle count reaches its limit.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results still outstanding",
               cycle_count, pending);
      $display("instruction_word_decoder regression: fail");
      $finish;
    end
  end

  // Build a word of the given operation; spare bits come from r so that
  // every operand bit gets both values over the run.
  function automatic logic [WordW-1:0] encode_op(input op_kind_e op,
                                                 input logic [WordW-1:0] r,
                                                 input int unsigned form);
    logic [WordW-1:0] w;
    case (op)
      OP_JUMP:     w = {TopJump, r[11:0]};
      OP_CALL:     w = {TopCall, r[11:0]};
      OP_SET_IDX:  w = {TopSetIdx, r[11:0]};
      OP_JUMP_OFS: w = {TopJmpOfs, r[11:0]};
      OP_CLS:      w = WordCls;
      OP_RET:      w = WordRet;
      OP_SKEQ_K:   w = {TopSkEqK, r[11:0]};
      OP_SKNE_K:   w = {TopSkNeK, r[11:0]};
      OP_SET_K:    w = {TopSetK, r[11:0]};
      OP_ADD_K:    w = {TopAddK, r[11:0]};
      OP_RAND:     w = {TopRand, r[11:0]};
      OP_SKEQ_R:   w = {TopSkEqR, r[11:4], 4'h0};
      OP_SKNE_R:   w = {TopSkNeR, r[11:4], 4'h0};
      OP_MOV:      w = {TopAlu, r[11:4], AluMov};
      OP_OR:       w = {TopAlu, r[11:4], AluOr};
      OP_AND:      w = {TopAlu, r[11:4], AluAnd};
      OP_XOR:      w = {TopAlu, r[11:4], AluXor};
      OP_ADD:      w = {TopAlu, r[11:4], AluAdd};
      OP_SUB:      w = {TopAlu, r[11:4], AluSub};
      OP_SUBN:     w = {TopAlu, r[11:4], AluSubn};
      OP_SHR:      w = {TopAlu, r[11:4], AluShr};
      OP_SHL:      w = {TopAlu, r[11:4], AluShl};
      OP_SKP_KEY:  w = {TopKey, r[11:8], KeySkp};
      OP_SKNP_KEY: w = {TopKey, r[11:8], KeySknp};
      OP_WAIT_KEY: w = {TopMisc, r[11:8], MiscWaitK};
      OP_GET_DT:   w = {TopMisc, r[11:8], MiscGetDt};
      OP_SET_DT:   w = {TopMisc, r[11:8], MiscSetDt};
      OP_SET_ST:   w = {TopMisc, r[11:8], MiscSetSt};
      OP_ADD_IDX:  w = {TopMisc, r[11:8], MiscAddI};
      OP_FONT:     w = {TopMisc, r[11:8], MiscFont};
      OP_BCD:      w = {TopMisc, r[11:8], MiscBcd};
      OP_STORE:    w = {TopMisc, r[11:8], MiscStore};
      OP_LOAD:     w = {TopMisc, r[11:8], MiscLoad};
      OP_DRAW:     w = {TopDraw, r[11:0]};
      default: begin
        // near misses: groups that need exact low bits, with random low bits
        case (form)
          0:       w = {TopSys, r[11:0]};
          1:       w = {TopSkEqR, r[11:0]};
          2:       w = {TopSkNeR, r[11:0]};
          3:       w = {TopAlu, r[11:0]};
          4:       w = {TopKey, r[11:0]};
          default: w = {TopMisc, r[11:0]};
        endcase
      end
    endcase
    return w;
  endfunction

  // Present one request, with random idle cycles ahead of it, and hold it
  // until the decoder takes it.
  task automatic send_word(input logic [WordW-1:0] w);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.instr_word <= w;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    words_sent++;
  endtask

  // Mostly well-formed words of a random operation, the rest raw noise.
  function automatic logic [WordW-1:0] random_word();
    logic [WordW-1:0] w;
    if ($urandom_range(99) < 80)
      w = encode_op(op_kind_e'($urandom_range(OP_DRAW)), WordW'($urandom),
                    $urandom_range(5));
    else
      w = WordW'($urandom);
    return w;
  endfunction

  initial begin
    int unsigned phase_items;
    logic [WordW-1:0] fill;

    // drive every input to a known value and hold reset
    rst_ni            = 1'b0;
    req_if.valid      = 1'b0;
    req_if.instr_word = '0;
    send_idle_pct     = 0;
    recv_idle_pct     = 0;
    words_sent        = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: every operation once, operand bits alternating all
    // ones and all zeros between operations.
    for (int op = OP_JUMP; op <= OP_DRAW; op++) begin
      fill = (op % 2 != 0) ? '1 : '0;
      send_word(encode_op(op_kind_e'(op), fill, 0));
    end
    // unrecognized forms: all-zero word, other 0NNN words, near misses of
    // 00E0 and 00EE, nonzero low nibble on the register skips, the unused
    // ALU nibbles, an unlisted key byte, and the all-ones word, whose misc byte is unlisted
    send_word('0);
    send_word({TopSys, 12'hFFF});
    send_word({TopSys, 12'h0E1});
    send_word({TopSys, 12'h1EE});
    send_word({TopSkEqR, 12'h5A1});
    send_word({TopSkNeR, 12'hA5F});
    send_word({TopAlu, 8'h3C, 4'h8});
    send_word({TopAlu, 8'hC3, 4'hF});
    send_word({TopKey, 12'h700});
    send_word('1);

    // Random part in three pacing phases; the last one fills up the run.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 13;
          recv_idle_pct = 52;
          phase_items   = PhaseItems;
        end
        1: begin
          send_idle_pct = 52;
          recv_idle_pct = 13;
          phase_items   = PhaseItems;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          phase_items   = TotalItems - words_sent;
        end
      endcase
      repeat (phase_items) send_word(random_word());
    end
    req_if.valid <= 1'b0;

    // drain: wait for every outstanding result, then let the pipe settle
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);

    $display("sent %0d instruction words, checked %0d results in %0d cycles",
             words_sent, result_count, cycle_count);
    $display("decoded %0d of 35 operation codes correctly under three stall mixes",
             ops_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("instruction_word_decoder regression: pass");
    end else begin
      $display("%0d mismatches, %0d results missing", fail_count, pending);
      $display("instruction_word_decoder regression: fail");
    end
    $finish;
  end

endmodule
